// ===== src/skt_pkg.sv =====
// Shared codes and defaults for the sorted key table.
`default_nettype none
package skt_pkg;

   localparam int SKT_DEPTH     = 256;
   localparam int SKT_KEY_WIDTH = 32;

   localparam int OP_WIDTH   = 3;
   localparam int POS_WIDTH  = 8;
   localparam int KEY_FIELD  = 32;
   localparam int CNT_FIELD  = 9;
   localparam int STAT_WIDTH = 2;

   localparam logic [OP_WIDTH-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_READ   = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_REMOVE = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_SEARCH = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_CLEAR  = 3'd4;

   localparam logic [STAT_WIDTH-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_WIDTH-1:0] ST_BAD_POS   = 2'd1;
   localparam logic [STAT_WIDTH-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STAT_WIDTH-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic load;        // capture compare flags for a new item
      logic shift_in;    // insert: open a gap at the boundary
      logic shift_out;   // remove: close the gap from the right
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ===== src/sorted_key_table.sv =====
// Sorted key table: top level with request control, result register and cell row.
//
// Items arrive on the req_ channel: operation in req_tuser, key and position in
// req_tdata. Each item yields exactly one result on the rsp_ channel: status in
// rsp_tuser, position, key and entry count in rsp_tdata.
// The keys sit in a row of DEPTH cells, one key per cell, kept in ascending
// order. In the cycle an item is accepted every cell compares its key with the
// request key and its index with the position; once these flags are registered,
// they are encoded into a position, the row shifts by one place for insert or
// remove, and the result is loaded into the output register.
// A new item is taken only once the last result is registered (req_tready is
// low while busy), so a compare cycle is followed by the update cycle of the row.
// While the receiver stalls, a held result blocks only the update cycle of the
// next item; that item is already accepted and waits with its flags captured.
// Reset empties the table (entry count zero) and drops any result in flight;
// the key cells themselves are not cleared.
`default_nettype none
module sorted_key_table
   import skt_pkg::*;
#(
   parameter int DEPTH     = SKT_DEPTH,
   parameter int KEY_WIDTH = SKT_KEY_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // key[31:0], position[39:32]
   input  wire logic [2:0]  req_tuser,   // operation[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // where_placed[7:0], key_out[39:8], entry_count[48:40]
   output logic [1:0]       rsp_tuser    // status[1:0]
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   logic                  busy_ff, busy_in;
   logic [OP_WIDTH-1:0]   op_ff, op_in;
   logic [KEY_WIDTH-1:0]  key_ff, key_in;
   logic [POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [55:0]           rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_user_ff, rsp_user_in;

   logic                  accept, done, full, pos_bad;
   logic [63:0]           req_key_wide;
   logic [KEY_WIDTH-1:0]  req_key, key_bus;
   logic [POS_WIDTH-1:0]  pos_bus;
   cell_ctrl_type         ctrl;

   logic [KEY_WIDTH-1:0]  cell_key [DEPTH];
   logic [DEPTH-1:0]      lt_vec, ge_vec, first_vec, hit_vec, sel_vec;

   logic [IW-1:0]         ins_pos, hit_pos;
   logic [KEY_WIDTH-1:0]  sel_key;
   logic                  found;

   logic [STAT_WIDTH-1:0] status;
   logic [31:0]           where_wide;
   logic [KEY_WIDTH-1:0]  kout;
   logic [63:0]           kout_wide;
   logic [31:0]           cnt_wide;

   assign req_key_wide = 64'(req_tdata[31:0]);
   assign req_key      = req_key_wide[KEY_WIDTH-1:0];
   assign req_tready   = !busy_ff;
   assign accept       = req_tvalid && req_tready;
   assign done         = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign full         = count_ff == CW'(DEPTH);
   assign pos_bad      = 32'(pos_ff) >= 32'(count_ff);
   assign key_bus      = busy_ff ? key_ff : req_key;
   assign pos_bus      = busy_ff ? pos_ff : req_tdata[39:32];

   assign ctrl.load      = accept;
   assign ctrl.shift_in  = done && (op_ff == OP_INSERT) && !full;
   assign ctrl.shift_out = done && (op_ff == OP_REMOVE) && !pos_bad;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] left_key, right_key;
      logic                 left_lt, left_ge;
      if (i == 0) begin : g_first
         assign left_key = '0;
         assign left_lt  = 1'b1;
         assign left_ge  = 1'b0;
      end else begin : g_mid
         assign left_key = cell_key[i-1];
         assign left_lt  = lt_vec[i-1];
         assign left_ge  = ge_vec[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_key = '0;
      end else begin : g_inner
         assign right_key = cell_key[i+1];
      end
      skt_cell #(
         .INDEX     (i),
         .KEY_WIDTH (KEY_WIDTH),
         .CW        (CW)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .key_bus   (key_bus),
         .pos       (pos_bus),
         .count     (count_ff),
         .left_key  (left_key),
         .right_key (right_key),
         .left_lt   (left_lt),
         .left_ge   (left_ge),
         .key       (cell_key[i]),
         .lt        (lt_vec[i]),
         .ge        (ge_vec[i]),
         .first_ge  (first_vec[i]),
         .hit       (hit_vec[i]),
         .sel       (sel_vec[i])
      );
   end

   // flag vectors have at most one bit set, so an OR of indexes encodes them
   always_comb begin
      ins_pos = '0;
      hit_pos = '0;
      sel_key = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_vec[i]) ins_pos = ins_pos | IW'(i);
         if (hit_vec[i])   hit_pos = hit_pos | IW'(i);
         sel_key = sel_key | (cell_key[i] & {KEY_WIDTH{sel_vec[i]}});
      end
      found = |hit_vec;
   end

   always_comb begin
      status     = ST_OK;
      where_wide = '0;
      kout       = '0;
      count_in   = count_ff;
      case (op_ff)
         OP_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               where_wide = 32'(ins_pos);
               count_in   = count_ff + CW'(1);
            end
         end
         OP_READ, OP_REMOVE: begin
            if (pos_bad) begin
               status = ST_BAD_POS;
            end else begin
               where_wide = 32'(pos_ff);
               kout       = sel_key;
               if (op_ff == OP_REMOVE) count_in = count_ff - CW'(1);
            end
         end
         OP_SEARCH: begin
            if (found) begin
               where_wide = 32'(hit_pos);
               kout       = key_ff;
            end else begin
               status = ST_NOT_FOUND;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign kout_wide = 64'(kout);

   always_comb begin
      busy_in      = busy_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      cnt_wide     = 32'(count_in);
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (accept) begin
         busy_in = 1'b1;
         op_in   = req_tuser;
         key_in  = req_key;
         pos_in  = req_tdata[39:32];
      end
      if (done) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_user_in  = status;
         rsp_data_in  = {7'b0, cnt_wide[CNT_FIELD-1:0], kout_wide[KEY_FIELD-1:0],
                         where_wide[POS_WIDTH-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (done) count_ff <= count_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(DEPTH))
      else $error("entry count beyond table depth");

   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $onehot0(hit_vec))
      else $error("search matched more than one cell");

   a_insert_boundary: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (op_ff == OP_INSERT) && !full) |-> $onehot(first_vec))
      else $error("insert boundary not unique");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (done && (op_ff == OP_CLEAR)) |=> (count_ff == '0))
      else $error("clear left entries behind");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      done |=> !rsp_valid_ff || (rsp_user_ff == $past(status)))
      else $error("result status lost");
`endif

endmodule
`default_nettype wire

// ===== src/skt_cell.sv =====
// One table cell: holds a key, its compare flags, and shifts with its neighbours.
`default_nettype none
module skt_cell
   import skt_pkg::*;
#(
   parameter int INDEX     = 0,
   parameter int KEY_WIDTH = SKT_KEY_WIDTH,
   parameter int CW        = 9
) (
   input  wire logic                 clock,
   input  wire cell_ctrl_type        ctrl,
   input  wire logic [KEY_WIDTH-1:0] key_bus,
   input  wire logic [POS_WIDTH-1:0] pos,
   input  wire logic [CW-1:0]        count,
   input  wire logic [KEY_WIDTH-1:0] left_key,
   input  wire logic [KEY_WIDTH-1:0] right_key,
   input  wire logic                 left_lt,
   input  wire logic                 left_ge,
   output logic [KEY_WIDTH-1:0]      key,
   output logic                      lt,
   output logic                      ge,
   output logic                      first_ge,
   output logic                      hit,
   output logic                      sel
);

   localparam logic [31:0] IDX = 32'(INDEX);

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 lt_ff, lt_in;
   logic                 eq_ff, eq_in;
   logic                 ge_ff, ge_in;
   logic                 valid;

   assign valid = IDX < 32'(count);

   always_comb begin
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      ge_in  = ge_ff;
      key_in = key_ff;
      if (ctrl.load) begin
         lt_in = valid && (key_ff < key_bus);
         eq_in = key_ff == key_bus;
         ge_in = IDX >= 32'(pos);
      end
      if (ctrl.shift_in && !lt_ff) begin
         key_in = left_lt ? key_bus : left_key;
      end else if (ctrl.shift_out && ge_ff) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
      ge_ff  <= ge_in;
   end

   assign key      = key_ff;
   assign lt       = lt_ff;
   assign ge       = ge_ff;
   assign first_ge = !lt_ff && left_lt;
   assign hit      = first_ge && eq_ff && valid;
   assign sel      = ge_ff && !left_ge;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for sorted_key_table: directed table, then random traffic checked against a predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import skt_pkg::*;

   localparam logic [OP_WIDTH-1:0] OP_RSVD5 = 3'd5;
   localparam logic [OP_WIDTH-1:0] OP_RSVD6 = 3'd6;
   localparam logic [OP_WIDTH-1:0] OP_RSVD7 = 3'd7;

   localparam int PHASE_ITEMS = 300;
   localparam int NUM_PHASES  = 4;
   localparam int SEND_IDLE [NUM_PHASES]  = '{0, 69, 0, 22};
   localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 69, 22};

   typedef struct packed {
      logic [STAT_WIDTH-1:0] status;
      logic [POS_WIDTH-1:0]  where_at;
      logic [KEY_FIELD-1:0]  key_out;
      logic [CNT_FIELD-1:0]  count;
   } skt_result_t;

   typedef struct packed {
      logic [OP_WIDTH-1:0]  op;
      logic [KEY_FIELD-1:0] key;
      logic [POS_WIDTH-1:0] pos;
      logic                 typed;
      skt_result_t          want;
   } skt_row_t;

   typedef enum {MODE_GROW, MODE_SHRINK, MODE_CHURN} traffic_mode_t;

   localparam int NUM_ROWS = 25;
   localparam skt_row_t DIRECTED_ROWS [NUM_ROWS] = '{
      {OP_READ,   32'h0000_0000, 8'd0,   1'b1, ST_BAD_POS,   8'd0, 32'h0000_0000, 9'd0},
      {OP_REMOVE, 32'h0000_0000, 8'd255, 1'b1, ST_BAD_POS,   8'd0, 32'h0000_0000, 9'd0},
      {OP_SEARCH, 32'h0000_0000, 8'd0,   1'b1, ST_NOT_FOUND, 8'd0, 32'h0000_0000, 9'd0},
      {OP_INSERT, 32'hffff_ffff, 8'd0,   1'b1, ST_OK,        8'd0, 32'h0000_0000, 9'd1},
      {OP_INSERT, 32'h0000_0000, 8'd0,   1'b1, ST_OK,        8'd0, 32'h0000_0000, 9'd2},
      // equal key goes in ahead of the one already there
      {OP_INSERT, 32'h0000_0000, 8'd77,  1'b1, ST_OK,        8'd0, 32'h0000_0000, 9'd3},
      {OP_INSERT, 32'h8000_0000, 8'd0,   1'b0, ST_OK,        8'd0, 32'h0000_0000, 9'd0},
      {OP_INSERT, 32'h7fff_ffff, 8'd0,   1'b0, ST_OK,        8'd0, 32'h0000_0000, 9'd0},
      {OP_READ,   32'h0000_0000, 8'd4,   1'b1, ST_OK,        8'd4, 32'hffff_ffff, 9'd5},
      {OP_READ,   32'h0000_0000, 8'd5,   1'b1, ST_BAD_POS,   8'd0, 32'h0000_0000, 9'd5},
      {OP_SEARCH, 32'hffff_ffff, 8'd0,   1'b0, ST_OK,        8'd0, 32'h0000_0000, 9'd0},
      {OP_SEARCH, 32'h0000_0000, 8'd3,   1'b1, ST_OK,        8'd0, 32'h0000_0000, 9'd5},
      {OP_SEARCH, 32'h1234_5678, 8'd0,   1'b1, ST_NOT_FOUND, 8'd0, 32'h0000_0000, 9'd5},
      {OP_RSVD5,  32'haaaa_5555, 8'haa,  1'b1, ST_OK,        8'd0, 32'h0000_0000, 9'd5},
      {OP_RSVD6,  32'h5555_aaaa, 8'h55,  1'b1, ST_OK,        8'd0, 32'h0000_0000, 9'd5},
      {OP_RSVD7,  32'hffff_ffff, 8'hff,  1'b1, ST_OK,        8'd0, 32'h0000_0000, 9'd5},
      {OP_REMOVE, 32'h0000_0000, 8'd2,   1'b0, ST_OK,        8'd0, 32'h0000_0000, 9'd0},
      {OP_REMOVE, 32'hffff_ffff, 8'd0,   1'b0, ST_OK,        8'd0, 32'h0000_0000, 9'd0},
      {OP_READ,   32'h0000_0000, 8'd1,   1'b0, ST_OK,        8'd0, 32'h0000_0000, 9'd0},
      {OP_REMOVE, 32'h0000_0000, 8'd3,   1'b1, ST_BAD_POS,   8'd0, 32'h0000_0000, 9'd3},
      {OP_CLEAR,  32'hffff_ffff, 8'hff,  1'b1, ST_OK,        8'd0, 32'h0000_0000, 9'd0},
      {OP_READ,   32'h0000_0000, 8'd0,   1'b1, ST_BAD_POS,   8'd0, 32'h0000_0000, 9'd0},
      // stale cells after a clear must not be found
      {OP_SEARCH, 32'h8000_0000, 8'd0,   1'b1, ST_NOT_FOUND, 8'd0, 32'h0000_0000, 9'd0},
      {OP_INSERT, 32'h5555_5555, 8'd0,   1'b1, ST_OK,        8'd0, 32'h0000_0000, 9'd1},
      {OP_CLEAR,  32'h0000_0000, 8'd0,   1'b1, ST_OK,        8'd0, 32'h0000_0000, 9'd0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // key[31:0], position[39:32]
   logic [2:0]  req_tuser  = '0;   // operation[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // where_placed[7:0], key_out[39:8], entry_count[48:40]
   logic [1:0]  rsp_tuser;         // status[1:0]

   logic [KEY_FIELD-1:0] shadow_keys [SKT_DEPTH];
   int                   shadow_count = 0;
   skt_result_t          pending_results [$];
   int                   error_count    = 0;
   int                   send_idle_pct  = 0;
   int                   recv_stall_pct = 0;

   sorted_key_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // lowest position whose key is not below k
   function automatic int lower_bound_pos(logic [KEY_FIELD-1:0] k);
      int lo, hi, mid;
      lo = 0;
      hi = shadow_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (shadow_keys[mid] < k) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic skt_result_t apply_to_table(logic [OP_WIDTH-1:0] op,
                                                  logic [KEY_FIELD-1:0] k,
                                                  logic [POS_WIDTH-1:0] pos);
      skt_result_t r;
      int p;
      r = '0;
      case (op)
         OP_INSERT: begin
            if (shadow_count >= SKT_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               p = lower_bound_pos(k);
               for (int j = shadow_count; j > p; j--) shadow_keys[j] = shadow_keys[j-1];
               shadow_keys[p] = k;
               shadow_count++;
               r.where_at = POS_WIDTH'(p);
            end
         end
         OP_READ, OP_REMOVE: begin
            if (int'(pos) >= shadow_count) begin
               r.status = ST_BAD_POS;
            end else begin
               r.where_at = pos;
               r.key_out  = shadow_keys[pos];
               if (op == OP_REMOVE) begin
                  for (int j = pos; j + 1 < shadow_count; j++) shadow_keys[j] = shadow_keys[j+1];
                  shadow_count--;
               end
            end
         end
         OP_SEARCH: begin
            p = lower_bound_pos(k);
            if (p < shadow_count && shadow_keys[p] == k) begin
               r.where_at = POS_WIDTH'(p);
               r.key_out  = k;
            end else begin
               r.status = ST_NOT_FOUND;
            end
         end
         OP_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      r.count = CNT_FIELD'(shadow_count);
      return r;
   endfunction

   // keys: copies of stored ones, extremes, a narrow range for duplicates, or anything
   function automatic logic [KEY_FIELD-1:0] pick_key();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 30 && shadow_count > 0) return shadow_keys[$urandom_range(0, shadow_count - 1)];
      if (roll < 45) begin
         case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            default: return 32'h7fff_ffff;
         endcase
      end
      if (roll < 60) return KEY_FIELD'($urandom_range(0, 15));
      return $urandom();
   endfunction

   function automatic logic [POS_WIDTH-1:0] pick_pos();
      if (shadow_count > 0 && $urandom_range(0, 99) < 80)
         return POS_WIDTH'($urandom_range(0, shadow_count - 1));
      return POS_WIDTH'($urandom_range(0, 255));
   endfunction

   function automatic logic [OP_WIDTH-1:0] pick_op(traffic_mode_t mode);
      int unsigned roll, ins_pct, rem_pct;
      roll    = $urandom_range(0, 99);
      ins_pct = (mode == MODE_GROW) ? 55 : (mode == MODE_SHRINK) ? 12 : 30;
      rem_pct = (mode == MODE_GROW) ? 8 : (mode == MODE_SHRINK) ? 50 : 25;
      if (roll < ins_pct) return OP_INSERT;
      if (roll < ins_pct + rem_pct) return OP_REMOVE;
      if (roll < 82) return OP_SEARCH;
      if (roll < 96) return OP_READ;
      if (roll < 97) return OP_CLEAR;
      return OP_WIDTH'($urandom_range(OP_RSVD5, OP_RSVD7));
   endfunction

   // present one item, wait for it to be taken, then log what should come back
   task automatic send_item(logic [OP_WIDTH-1:0] op, logic [KEY_FIELD-1:0] k,
                            logic [POS_WIDTH-1:0] pos, logic typed, skt_result_t want);
      skt_result_t predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {pos, k};
      do @(posedge clock); while (!req_tready);
      predicted = apply_to_table(op, k, pos);
      pending_results.push_back(typed ? want : predicted);
   endtask

   function automatic void check_field(string field, logic [KEY_FIELD-1:0] want,
                                       logic [KEY_FIELD-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      skt_result_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[7:0], rsp_tdata[39:8], rsp_tdata[48:40]};
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %h", $realtime, got);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", KEY_FIELD'(want.status), KEY_FIELD'(got.status));
            check_field("where_placed", KEY_FIELD'(want.where_at), KEY_FIELD'(got.where_at));
            check_field("key_out", want.key_out, got.key_out);
            check_field("entry_count", KEY_FIELD'(want.count), KEY_FIELD'(got.count));
         end
      end
   end

   initial begin
      traffic_mode_t mode;
      int sent, wait_cycles;
      mode = MODE_CHURN;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_ROWS; i++)
         send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].pos,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         send_idle_pct  = SEND_IDLE[phase];
         recv_stall_pct = RECV_STALL[phase];
         // run the table up to capacity and push past it
         if (phase == 0 || phase == NUM_PHASES - 1) begin
            while (shadow_count < SKT_DEPTH) send_item(OP_INSERT, pick_key(), pick_pos(), 1'b0, '0);
            repeat (3) send_item(OP_INSERT, pick_key(), pick_pos(), 1'b0, '0);
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (sent % 40 == 0) mode = traffic_mode_t'($urandom_range(0, 2));
            send_item(pick_op(mode), pick_key(), pick_pos(), 1'b0, '0);
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (pending_results.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d items never arrived, first expected %h", $realtime,
                  pending_results.size(), pending_results[0]);
         error_count++;
      end
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
src/skt_pkg.sv
src/skt_cell.sv
src/sorted_key_table.sv
tb/sv/testbench.sv
